// ===== rtl/core/sccb_pkg.sv =====
`default_nettype none

package sccb_pkg;

  localparam int BYTE_W = 8;
  localparam int WAIT_W = 16;
  localparam int CMD_W  = 3;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0]  BITS_PER_BYTE = CNT_W'(BYTE_W);
  localparam logic [WAIT_W-1:0] HALF_BIT_RESET = WAIT_W'(50);

  // Register byte addresses on the configuration port.
  localparam logic [ADDR_W-1:0] ADDR_HALF_BIT = ADDR_W'(0);

  localparam logic [CMD_W-1:0] CMD_START = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_STOP  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_WRITE = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_READ  = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_NOACK = CMD_W'(4);

  typedef struct packed {
    logic              req_valid;
    logic [CMD_W-1:0]  req_type;
    logic [BYTE_W-1:0] wr_byte;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic              ack_ok;
    logic [BYTE_W-1:0] rd_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sccb_regs.sv =====
`default_nettype none

module sccb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sccb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sccb_pkg::DATA_W-1:0] pwdata,
  output logic      [sccb_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [sccb_pkg::WAIT_W-1:0] half_bit_ticks
);
  import sccb_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= HALF_BIT_RESET;
    end else if (wr_en && paddr == ADDR_HALF_BIT) begin
      half_bit_ticks <= pwdata[WAIT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_HALF_BIT) begin
      prdata = DATA_W'(half_bit_ticks);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sccb_engine.sv =====
`default_nettype none

module sccb_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step_en,
  input  wire sccb_pkg::item_t             item,
  input  wire logic [sccb_pkg::WAIT_W-1:0] half_bit_ticks,
  output sccb_pkg::res_t                   res
);
  import sccb_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_A,
    PH_B,
    PH_C,
    PH_D
  } phase_t;

  phase_t            phase, phase_next;
  logic [CMD_W-1:0]  active_cmd, active_cmd_next;
  logic [CNT_W-1:0]  bit_count, bit_count_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [BYTE_W-1:0] shift_reg, shift_reg_next;
  logic              clock_level, clock_level_next;
  logic              data_level, data_level_next;
  logic              data_driven, data_driven_next;
  logic              ack_flag, ack_flag_next;
  logic [BYTE_W-1:0] read_hold, read_hold_next;

  logic [WAIT_W-1:0] wait_len;
  logic [WAIT_W-1:0] wait_dec;
  logic [CNT_W-1:0]  bit_inc;
  logic              done;

  assign wait_len = (half_bit_ticks == '0) ? WAIT_W'(1) : half_bit_ticks;
  assign wait_dec = wait_count - WAIT_W'(1);
  assign bit_inc  = bit_count + CNT_W'(1);

  always_comb begin
    phase_next       = phase;
    active_cmd_next  = active_cmd;
    bit_count_next   = bit_count;
    wait_count_next  = wait_count;
    shift_reg_next   = shift_reg;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    data_driven_next = data_driven;
    ack_flag_next    = ack_flag;
    read_hold_next   = read_hold;
    done             = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.req_valid && item.req_type <= CMD_NOACK) begin
        active_cmd_next = item.req_type;
        phase_next      = PH_A;
        bit_count_next  = '0;
        wait_count_next = wait_len;
        case (item.req_type)
          CMD_START: begin
            data_level_next  = 1'b1;
            clock_level_next = 1'b1;
          end
          CMD_STOP: begin
            data_level_next = 1'b0;
          end
          CMD_WRITE: begin
            data_level_next = item.wr_byte[BYTE_W-1];
            shift_reg_next  = {item.wr_byte[BYTE_W-2:0], 1'b0};
          end
          CMD_READ: begin
            data_driven_next = 1'b0;
            shift_reg_next   = '0;
          end
          default: begin
          end
        endcase
      end
    end else if (wait_dec != '0) begin
      wait_count_next = wait_dec;
    end else begin
      // End of a wait: play the next edges of the active command.
      wait_count_next = wait_len;
      case (phase)
        PH_A:    phase_next = PH_B;
        PH_B:    phase_next = PH_C;
        PH_C:    phase_next = PH_D;
        default: phase_next = PH_IDLE;
      endcase
      case (active_cmd)
        CMD_START: begin
          if (phase == PH_A) begin
            data_level_next = 1'b0;
          end else begin
            clock_level_next = 1'b0;
            done             = 1'b1;
          end
        end
        CMD_STOP: begin
          if (phase == PH_A) begin
            clock_level_next = 1'b1;
          end else if (phase == PH_B) begin
            data_level_next = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        CMD_NOACK: begin
          if (phase == PH_A) begin
            data_level_next  = 1'b1;
            clock_level_next = 1'b1;
          end else if (phase == PH_B) begin
            clock_level_next = 1'b0;
          end else if (phase == PH_C) begin
            data_level_next = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (phase == PH_A) begin
            clock_level_next = 1'b1;
          end else if (phase == PH_B) begin
            clock_level_next = 1'b0;
            bit_count_next   = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              data_level_next = shift_reg[BYTE_W-1];
              shift_reg_next  = {shift_reg[BYTE_W-2:0], 1'b0};
              phase_next      = PH_A;
            end else begin
              data_driven_next = 1'b0;
            end
          end else if (phase == PH_C) begin
            clock_level_next = 1'b1;
          end else begin
            ack_flag_next    = !item.sda_in;
            clock_level_next = 1'b0;
            data_driven_next = 1'b1;
            done             = 1'b1;
          end
        end
        CMD_READ: begin
          if (phase == PH_A) begin
            clock_level_next = 1'b1;
            shift_reg_next   = {shift_reg[BYTE_W-2:0], item.sda_in};
          end else begin
            clock_level_next = 1'b0;
            bit_count_next   = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_next = PH_A;
            end else begin
              data_driven_next = 1'b1;
              read_hold_next   = shift_reg;
              done             = 1'b1;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        phase_next      = PH_IDLE;
        wait_count_next = wait_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_cmd  <= CMD_START;
      bit_count   <= '0;
      wait_count  <= '0;
      shift_reg   <= '0;
      clock_level <= 1'b1;
      data_level  <= 1'b1;
      data_driven <= 1'b1;
      ack_flag    <= 1'b0;
      read_hold   <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      active_cmd  <= active_cmd_next;
      bit_count   <= bit_count_next;
      wait_count  <= wait_count_next;
      shift_reg   <= shift_reg_next;
      clock_level <= clock_level_next;
      data_level  <= data_level_next;
      data_driven <= data_driven_next;
      ack_flag    <= ack_flag_next;
      read_hold   <= read_hold_next;
    end
  end

  always_comb begin
    res.scl_out   = clock_level_next;
    res.sda_out   = data_driven_next && data_level_next;
    res.sda_drive = data_driven_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.ack_ok    = ack_flag_next;
    res.rd_byte   = read_hold_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sccb_master_bit_engine.sv =====
// SCCB master bit engine.
// Each word on the input channel is one timing tick: an optional command
// (req_valid with req_type and, for a write, wr_byte) and the sampled data
// line sda_in. For every tick accepted, exactly one word leaves on the output
// channel with the clock and data line levels, the drive enable, busy and done
// flags, the last acknowledge and the last byte read, all as they stand after
// that tick. Commands that arrive while a sequence is running are dropped.
// The wait between line edges is set by the half_bit_ticks register on the
// APB port; configure it only while the engine is idle.
// An accepted tick passes through the input register, then the next-state
// logic feeding the output register. One tick is taken every cycle while
// the receiver does not stall the output word.
// When the receiver stalls, the output word holds and the input register
// stalls in turn once it is full; no tick is lost or repeated.
// Synchronous reset empties both registers and returns the bus to idle
// (clock and data high, data driven) with half_bit_ticks at 50.
`default_nettype none

module sccb_master_bit_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        req_valid,
  input  wire logic [sccb_pkg::CMD_W-1:0]  req_type,
  input  wire logic [sccb_pkg::BYTE_W-1:0] wr_byte,
  input  wire logic                        sda_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             scl_out,
  output logic                             sda_out,
  output logic                             sda_drive,
  output logic                             busy_res,
  output logic                             done_res,
  output logic                             ack_ok,
  output logic      [sccb_pkg::BYTE_W-1:0] rd_byte,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sccb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sccb_pkg::DATA_W-1:0] pwdata,
  output logic      [sccb_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import sccb_pkg::*;

  logic              in_full;
  item_t             item_r;
  logic              advance;
  logic [WAIT_W-1:0] half_bit_ticks;
  res_t              res;
  res_t              res_r;

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  sccb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .half_bit_ticks(half_bit_ticks)
  );

  sccb_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step_en       (advance),
    .item          (item_r),
    .half_bit_ticks(half_bit_ticks),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.req_valid <= req_valid;
      item_r.req_type  <= req_type;
      item_r.wr_byte   <= wr_byte;
      item_r.sda_in    <= sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign scl_out   = res_r.scl_out;
  assign sda_out   = res_r.sda_out;
  assign sda_drive = res_r.sda_drive;
  assign busy_res  = res_r.busy_res;
  assign done_res  = res_r.done_res;
  assign ack_ok    = res_r.ack_ok;
  assign rd_byte   = res_r.rd_byte;

endmodule

`default_nettype wire

// ===== rtl/core/sccb_checker.sv =====
`default_nettype none

module sccb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic sda_out,
  input wire logic sda_drive,
  input wire logic busy_res,
  input wire logic done_res
);

  // A completing word always shows the engine idle again.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done word still shows busy");

  // A released data line never shows a driven level.
  a_released_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_drive |-> !sda_out)
    else $error("sda_out high while the line is released");

  // The input side only backs up when the output side is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

endmodule

bind sccb_master_bit_engine sccb_checker u_sccb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .sda_out  (sda_out),
  .sda_drive(sda_drive),
  .busy_res (busy_res),
  .done_res (done_res)
);

`default_nettype wire

// ===== tb/sccb_master_bit_engine_tb.sv =====
module sccb_master_bit_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sccb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_5 = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = CMD_W'(7);
  localparam int HOLD_CYCLES = 400;
  localparam int CMDS_PER_SETTING = 8;
  localparam int LONG_WAIT_TICKS = 16;
  localparam logic [WAIT_W-1:0] DIRECTED_HALF_BIT = WAIT_W'(1);
  localparam logic [WAIT_W-1:0] HALF_BIT_PLAN [6] = '{1, 0, 3, 2, 6, 1};

  localparam res_t BUS_IDLE = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam res_t BUS_START = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam res_t NO_WANT = '0;

  // One directed command. For a read, sda_pattern is the byte the slave returns;
  // otherwise its lowest bit is the level on the data line (0 acknowledges).
  typedef struct packed {
    logic              req_valid;
    logic [CMD_W-1:0]  req_type;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] sda_pattern;
    logic              typed;
    res_t              want;
  } step_row_t;

  localparam step_row_t PLAN [16] = '{
    '{1'b0, CMD_START,  8'h00, 8'h00, 1'b1, BUS_IDLE},
    '{1'b1, CMD_RSVD_5, 8'h00, 8'h00, 1'b1, BUS_IDLE},
    '{1'b1, CMD_RSVD_6, 8'hFF, 8'h00, 1'b1, BUS_IDLE},
    '{1'b1, CMD_RSVD_7, 8'h00, 8'hFF, 1'b1, BUS_IDLE},
    '{1'b0, CMD_WRITE,  8'hFF, 8'h00, 1'b1, BUS_IDLE},
    '{1'b1, CMD_START,  8'h00, 8'h00, 1'b1, BUS_START},
    '{1'b1, CMD_WRITE,  8'hFF, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CMD_WRITE,  8'h00, 8'hFF, 1'b0, NO_WANT},
    '{1'b1, CMD_WRITE,  8'hA5, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CMD_WRITE,  8'h80, 8'h01, 1'b0, NO_WANT},
    '{1'b1, CMD_READ,   8'h00, 8'hFF, 1'b0, NO_WANT},
    '{1'b1, CMD_READ,   8'hFF, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CMD_READ,   8'h00, 8'h5A, 1'b0, NO_WANT},
    '{1'b1, CMD_NOACK,  8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CMD_STOP,   8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CMD_START,  8'h3C, 8'h00, 1'b0, NO_WANT}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_valid;
  logic [CMD_W-1:0] req_type;
  logic [BYTE_W-1:0] wr_byte;
  logic sda_in;
  logic out_valid;
  logic out_stall;
  logic scl_out;
  logic sda_out;
  logic sda_drive;
  logic busy_res;
  logic done_res;
  logic ack_ok;
  logic [BYTE_W-1:0] rd_byte;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sccb_master_bit_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_valid(req_valid), .req_type(req_type), .wr_byte(wr_byte), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_out(scl_out), .sda_out(sda_out), .sda_drive(sda_drive), .busy_res(busy_res),
    .done_res(done_res), .ack_ok(ack_ok), .rd_byte(rd_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Engine state as the predictor sees it.
  logic [WAIT_W-1:0] half_bit;
  logic [3:0]        eng_phase;
  logic [CMD_W-1:0]  eng_cmd;
  logic [CNT_W-1:0]  bit_idx;
  logic [WAIT_W-1:0] tick_left;
  logic [BYTE_W-1:0] shreg;
  logic              bus_scl;
  logic              bus_sda;
  logic              sda_owned;
  logic              ack_seen;
  logic [BYTE_W-1:0] last_read;

  res_t bus_state_q[$];
  int   fail_count = 0;
  int   words_checked = 0;
  int   ticks_sent = 0;
  int   cmd_count [5] = '{0, 0, 0, 0, 0};
  int   send_idle = 7;
  int   recv_idle = 47;
  logic hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d words still expected.", bus_state_q.size());
    $display("sccb_master_bit_engine: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want_v);
    fail_count++;
    if (fail_count <= 20)
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want_v);
  endtask

  function automatic logic [WAIT_W-1:0] wait_ticks();
    return (half_bit == '0) ? WAIT_W'(1) : half_bit;
  endfunction

  function automatic void shift_out_bit();
    bus_sda = shreg[BYTE_W-1];
    shreg = shreg << 1;
  endfunction

  // Line edges at the end of a wait; returns 1 when the command has finished.
  function automatic logic edges_after_wait(input logic sda);
    logic [3:0] p;
    p = eng_phase;
    eng_phase = p + 4'd1;
    case (eng_cmd)
      CMD_START: begin
        if (p == 4'd1) begin
          bus_sda = 1'b0;
          return 1'b0;
        end
        bus_scl = 1'b0;
        return 1'b1;
      end
      CMD_STOP: begin
        if (p == 4'd1) begin
          bus_scl = 1'b1;
          return 1'b0;
        end
        if (p == 4'd2) begin
          bus_sda = 1'b1;
          return 1'b0;
        end
        return 1'b1;
      end
      CMD_NOACK: begin
        if (p == 4'd1) begin
          bus_sda = 1'b1;
          bus_scl = 1'b1;
          return 1'b0;
        end
        if (p == 4'd2) begin
          bus_scl = 1'b0;
          return 1'b0;
        end
        if (p == 4'd3) begin
          bus_sda = 1'b0;
          return 1'b0;
        end
        return 1'b1;
      end
      CMD_WRITE: begin
        if (p == 4'd1) begin
          bus_scl = 1'b1;
          return 1'b0;
        end
        if (p == 4'd2) begin
          bus_scl = 1'b0;
          bit_idx = bit_idx + 1'b1;
          if (bit_idx < BITS_PER_BYTE) begin
            shift_out_bit();
            eng_phase = 4'd1;
          end else begin
            sda_owned = 1'b0;
          end
          return 1'b0;
        end
        if (p == 4'd3) begin
          bus_scl = 1'b1;
          return 1'b0;
        end
        ack_seen = ~sda;
        bus_scl = 1'b0;
        sda_owned = 1'b1;
        return 1'b1;
      end
      CMD_READ: begin
        if (p == 4'd1) begin
          bus_scl = 1'b1;
          shreg = {shreg[BYTE_W-2:0], sda};
          return 1'b0;
        end
        bus_scl = 1'b0;
        bit_idx = bit_idx + 1'b1;
        if (bit_idx < BITS_PER_BYTE) begin
          eng_phase = 4'd1;
          return 1'b0;
        end
        sda_owned = 1'b1;
        last_read = shreg;
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void advance_engine(input item_t t, output res_t r);
    logic done;
    done = 1'b0;
    if (eng_phase == '0) begin
      if (t.req_valid && t.req_type <= CMD_NOACK) begin
        eng_cmd = t.req_type;
        eng_phase = 4'd1;
        bit_idx = '0;
        tick_left = wait_ticks();
        case (t.req_type)
          CMD_START: begin
            bus_sda = 1'b1;
            bus_scl = 1'b1;
          end
          CMD_STOP: bus_sda = 1'b0;
          CMD_WRITE: begin
            shreg = t.wr_byte;
            shift_out_bit();
          end
          CMD_READ: begin
            sda_owned = 1'b0;
            shreg = '0;
          end
          default: ;
        endcase
      end
    end else begin
      tick_left = tick_left - 1'b1;
      if (tick_left == '0) begin
        if (edges_after_wait(t.sda_in)) begin
          eng_phase = '0;
          done = 1'b1;
        end else begin
          tick_left = wait_ticks();
        end
      end
    end
    r.scl_out = bus_scl;
    r.sda_out = sda_owned & bus_sda;
    r.sda_drive = sda_owned;
    r.busy_res = (eng_phase != '0);
    r.done_res = done;
    r.ack_ok = ack_seen;
    r.rd_byte = last_read;
  endfunction

  // Level the slave puts on the data line for a directed command.
  function automatic logic slave_level(input logic [BYTE_W-1:0] sda_pattern);
    if (eng_phase != '0 && eng_cmd == CMD_READ)
      return sda_pattern[3'd7 - bit_idx[2:0]];
    return sda_pattern[0];
  endfunction

  // A tick whose command fields are random; the engine drops them while busy.
  function automatic item_t busy_tick();
    item_t t;
    t.req_valid = 1'($urandom_range(1));
    t.req_type = CMD_W'($urandom_range(7));
    t.wr_byte = BYTE_W'($urandom);
    t.sda_in = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic item_t command_tick();
    item_t t;
    int r;
    t = busy_tick();
    if ($urandom_range(99) >= 10) begin
      t.req_valid = 1'b1;
      r = $urandom_range(99);
      if (r < 15)      t.req_type = CMD_START;
      else if (r < 30) t.req_type = CMD_STOP;
      else if (r < 60) t.req_type = CMD_WRITE;
      else if (r < 85) t.req_type = CMD_READ;
      else             t.req_type = CMD_NOACK;
    end
    return t;
  endfunction

  task automatic send_tick(input item_t t, input logic typed, input res_t want);
    res_t r;
    logic was_idle;
    logic ok;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_valid <= t.req_valid;
    req_type <= t.req_type;
    wr_byte <= t.wr_byte;
    sda_in <= t.sda_in;
    do begin
      @(negedge clk);
      ok = ~in_stall;
      @(posedge clk);
    end while (!ok);
    was_idle = (eng_phase == '0);
    advance_engine(t, r);
    bus_state_q.push_back(typed ? want : r);
    ticks_sent++;
    if (was_idle && eng_phase != '0)
      cmd_count[t.req_type]++;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] a, output logic [DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    d = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the running command finish and every output word drain, so that the
  // register is never written under a live sequence.
  task automatic settle_engine();
    while (eng_phase != '0)
      send_tick(busy_tick(), 1'b0, NO_WANT);
    in_valid <= 1'b0;
    while (bus_state_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_half_bit(input logic [WAIT_W-1:0] v);
    logic [DATA_W-1:0] rb;
    settle_engine();
    apb_write(ADDR_HALF_BIT, DATA_W'(v));
    @(posedge clk);
    apb_read(ADDR_HALF_BIT, rb);
    if (rb != DATA_W'(v))
      report_mismatch("half_bit_ticks readback", int'(rb), int'(v));
    half_bit = v;
  endtask

  task automatic run_commands(input int target);
    int first;
    int gap;
    first = cmd_count.sum();
    while (cmd_count.sum() - first < target) begin
      send_tick(command_tick(), 1'b0, NO_WANT);
      while (eng_phase != '0)
        send_tick(busy_tick(), 1'b0, NO_WANT);
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (gap) send_tick(busy_tick() & ~item_t'({1'b1, 12'h000}), 1'b0, NO_WANT);
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Output words are sampled at the falling edge, where they hold the values
  // seen by the next rising edge.
  initial begin
    res_t exp_w;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (bus_state_q.size() == 0) begin
          report_mismatch("output word with nothing expected, scl_out", int'(scl_out), 0);
        end else begin
          exp_w = bus_state_q.pop_front();
          words_checked++;
          if (scl_out !== exp_w.scl_out)
            report_mismatch("scl_out", int'(scl_out), int'(exp_w.scl_out));
          if (sda_out !== exp_w.sda_out)
            report_mismatch("sda_out", int'(sda_out), int'(exp_w.sda_out));
          if (sda_drive !== exp_w.sda_drive)
            report_mismatch("sda_drive", int'(sda_drive), int'(exp_w.sda_drive));
          if (busy_res !== exp_w.busy_res)
            report_mismatch("busy_res", int'(busy_res), int'(exp_w.busy_res));
          if (done_res !== exp_w.done_res)
            report_mismatch("done_res", int'(done_res), int'(exp_w.done_res));
          if (ack_ok !== exp_w.ack_ok)
            report_mismatch("ack_ok", int'(ack_ok), int'(exp_w.ack_ok));
          if (rd_byte !== exp_w.rd_byte)
            report_mismatch("rd_byte", int'(rd_byte), int'(exp_w.rd_byte));
        end
      end
    end
  end

  initial begin
    item_t t;
    step_row_t row;
    logic [DATA_W-1:0] rb;
    int k;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_valid <= 1'b0;
    req_type <= CMD_START;
    wr_byte <= '0;
    sda_in <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HALF_BIT;
    pwdata <= '0;
    half_bit = HALF_BIT_RESET;
    eng_phase = '0;
    eng_cmd = CMD_START;
    bit_idx = '0;
    tick_left = '0;
    shreg = '0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    sda_owned = 1'b1;
    ack_seen = 1'b0;
    last_read = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_read(ADDR_HALF_BIT, rb);
    if (rb != DATA_W'(HALF_BIT_RESET))
      report_mismatch("half_bit_ticks after reset", int'(rb), int'(HALF_BIT_RESET));

    // The directed rows run with one tick per wait.
    set_half_bit(DIRECTED_HALF_BIT);
    foreach (PLAN[i]) begin
      row = PLAN[i];
      t.req_valid = row.req_valid;
      t.req_type = row.req_type;
      t.wr_byte = row.wr_byte;
      t.sda_in = slave_level(row.sda_pattern);
      send_tick(t, row.typed, row.want);
      while (eng_phase != '0) begin
        t = busy_tick();
        t.sda_in = slave_level(row.sda_pattern);
        send_tick(t, 1'b0, NO_WANT);
      end
    end

    // Two settings per idling mode; the long receiver hold-off opens the first.
    for (k = 0; k < 6; k++) begin
      set_half_bit(HALF_BIT_PLAN[k]);
      send_idle = (k < 2) ? 7 : (k < 4) ? 47 : 0;
      recv_idle = (k < 2) ? 47 : (k < 4) ? 7 : 0;
      if (k == 0)
        hold_off_req = 1'b1;
      run_commands(CMDS_PER_SETTING);
    end

    // Longest wait: a start condition is begun and a few ticks of its first
    // wait are played, since one wait alone lasts 65535 ticks.
    set_half_bit({WAIT_W{1'b1}});
    t = busy_tick();
    t.req_valid = 1'b1;
    t.req_type = CMD_START;
    send_tick(t, 1'b0, NO_WANT);
    repeat (LONG_WAIT_TICKS)
      send_tick(busy_tick(), 1'b0, NO_WANT);
    in_valid <= 1'b0;

    for (k = 0; k < 2000 && bus_state_q.size() != 0; k++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (bus_state_q.size() != 0)
      report_mismatch("words never delivered", 0, bus_state_q.size());

    $display("Run covered %0d ticks with %0d start, %0d stop, %0d write, %0d read, %0d no-ack.",
             ticks_sent, cmd_count[CMD_START], cmd_count[CMD_STOP], cmd_count[CMD_WRITE],
             cmd_count[CMD_READ], cmd_count[CMD_NOACK]);
    $display("Reset length 50 read back; half-bit lengths 1, 0, 3, 2, 6 and 65535 used;");
    $display("%0d words compared, %0d errors.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("sccb_master_bit_engine: match");
    end else begin
      $display("sccb_master_bit_engine: mismatch");
    end
    $finish;
  end

endmodule
